// File: rtl/kss_pkg.sv
`timescale 1ns / 1ps
// shared constants for the scalar kalman smoother
// no dependencies; imported by the divider, multiplier and top level

package kss_pkg;

   // fixed-point widths
   localparam int unsigned DATA_W  = 32;  // q16.16 values
   localparam int unsigned GAIN_W  = 17;  // q1.16 gain, one included
   localparam int unsigned DEN_W   = 33;  // r + p, one bit of growth
   localparam int unsigned MCAND_W = 33;  // signed multiplicand
   localparam int unsigned ACC_W   = 34;  // upper part of a serial product
   localparam int unsigned CNT_W   = 5;   // step counter of the serial units

   // index of the last serial step: one step per gain bit
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_W - 1);

   // gain of one in q1.16
   localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

   // register map
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COVARIANCE = 2'd2;

   // register reset values
   localparam logic [DATA_W-1:0] PROCESS_NOISE_RST      = 32'd655;
   localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST  = 32'd65536;
   localparam logic [DATA_W-1:0] INITIAL_COVARIANCE_RST = 32'd65536;

   // saturation limits of the estimate
   localparam logic [DATA_W-1:0] EST_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] EST_MIN = 32'h8000_0000;

endpackage

// File: rtl/kss_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider for the kalman gain: floor(p * 65536 / den)
// uses kss_pkg; one quotient bit per cycle

module kss_div
   import kss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DATA_W-1:0]   numer,
   input  logic [DEN_W-1:0]    denom,
   output logic                done,
   output logic [GAIN_W-1:0]   quotient
);

   logic [ACC_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [GAIN_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [ACC_W:0]     trial;
   logic               qbit;
   logic [ACC_W-1:0]   rem_keep;

   // one trial subtraction per step
   always_comb begin
      trial    = {1'b0, rem_ff} - {2'b00, den_ff};
      qbit     = ~trial[ACC_W];
      rem_keep = qbit ? trial[ACC_W-1:0] : rem_ff;
   end

   // step sequencing
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {2'b00, numer};
         den_in  = denom;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = {rem_keep[ACC_W-2:0], 1'b0};
         quo_in = {quo_ff[GAIN_W-2:0], qbit};
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/kss_mul.sv
`timescale 1ns / 1ps
// bit-serial shift-add multiplier: signed 33-bit times unsigned 17-bit
// uses kss_pkg; one multiplier bit per cycle

module kss_mul
   import kss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [MCAND_W-1:0]        mcand,
   input  logic [GAIN_W-1:0]         mplier,
   output logic                      done,
   output logic [ACC_W+GAIN_W-1:0]   product
);

   logic [MCAND_W-1:0]  mcand_ff, mcand_in;
   logic [ACC_W-1:0]    hi_ff, hi_in;
   logic [GAIN_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [ACC_W:0]      addend;
   logic [ACC_W:0]      sum;

   // add the multiplicand when the low multiplier bit is set, then shift right
   always_comb begin
      addend = lo_ff[0] ? {{(ACC_W+1-MCAND_W){mcand_ff[MCAND_W-1]}}, mcand_ff} : '0;
      sum    = {hi_ff[ACC_W-1], hi_ff} + addend;
   end

   // step sequencing
   always_comb begin
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in = sum[ACC_W:1];
         lo_in = {sum[0], lo_ff[GAIN_W-1:1]};
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// File: rtl/scalar_kalman_smoother_top.sv
`timescale 1ns / 1ps
// Scalar Kalman smoother: one measurement in, one estimate and gain out.
// Each sample passes from its transfer to its result through prediction, a
// bit-serial divider for the gain, a step to take the gain and one to start
// the multipliers, then two bit-serial multipliers running side by side for
// the estimate and the covariance, a step to see them finish, and a step of
// rounding and saturation. A new sample is taken the cycle after the result
// is registered, even while that result is still stalled; a further result
// waits until the output register is free. Configuration writes are always
// ready; writing initial_covariance also reloads the running covariance.
// Uses kss_pkg, kss_div and kss_mul.

module scalar_kalman_smoother_top
   import kss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // sample channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DATA_W-1:0]      req_sample,
   input  logic                   req_restart,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DATA_W-1:0]      rsp_estimate,
   output logic [GAIN_W-1:0]      rsp_kalman_gain,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRED = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MST  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   localparam int unsigned PROD_W = ACC_W + GAIN_W;
   localparam int unsigned DLT_W  = PROD_W - 16;
   localparam int unsigned EST_W  = DLT_W + 1;

   logic [2:0]           state_ff, state_in;
   logic [DATA_W-1:0]    q_ff, r_ff;
   logic [DATA_W-1:0]    x_ff, x_in;
   logic [DATA_W-1:0]    cov_ff, cov_in;
   logic                 seeded_ff, seeded_in;
   logic [DATA_W-1:0]    z_ff;
   logic [DATA_W-1:0]    p_ff;
   logic                 dzero_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_est_ff;
   logic [GAIN_W-1:0]    rsp_gain_ff;

   logic                 req_xfer, rsp_xfer, csr_xfer, out_free;
   logic [DATA_W:0]      p_sum;
   logic [DATA_W-1:0]    p_sat;
   logic [DEN_W-1:0]     den;
   logic                 div_start, div_done;
   logic [GAIN_W-1:0]    div_quo;
   logic                 mul_start, mul_est_done, mul_cov_done;
   logic [MCAND_W-1:0]   diff;
   logic [GAIN_W-1:0]    one_minus_gain;
   logic [PROD_W-1:0]    prod_est, prod_cov;
   logic [DLT_W-1:0]     delta;
   logic [EST_W-1:0]     est_sum;
   logic [DATA_W-1:0]    est_sat;
   logic [DEN_W-1:0]     cov_full;
   logic [DATA_W-1:0]    cov_new;

   // handshakes
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_xfer  = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // prediction: p + q saturated, denominator r + p
   always_comb begin
      p_sum = {1'b0, cov_ff} + {1'b0, q_ff};
      p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
      den   = {1'b0, r_ff} + {1'b0, p_sat};
   end

   // gain division
   assign div_start = (state_ff == ST_PRED);

   kss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (p_sat),
      .denom    (den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // innovation and the complement of the gain
   always_comb begin
      diff           = {z_ff[DATA_W-1], z_ff} - {x_ff[DATA_W-1], x_ff};
      one_minus_gain = ONE_Q16 - gain_ff;
   end

   assign mul_start = (state_ff == ST_MST);

   kss_mul u_mul_est (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (diff),
      .mplier  (gain_ff),
      .done    (mul_est_done),
      .product (prod_est)
   );

   kss_mul u_mul_cov (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   ({1'b0, p_ff}),
      .mplier  (one_minus_gain),
      .done    (mul_cov_done),
      .product (prod_cov)
   );

   // round the estimate and the covariance to nearest, halves up, then saturate the estimate
   always_comb begin
      delta    = prod_est[PROD_W-1:16] + {{(DLT_W-1){1'b0}}, prod_est[15]};
      est_sum  = {{(EST_W-DATA_W){x_ff[DATA_W-1]}}, x_ff} + {delta[DLT_W-1], delta};
      if (!est_sum[EST_W-1] && (est_sum[EST_W-2:DATA_W-1] != '0)) begin
         est_sat = EST_MAX;
      end else if (est_sum[EST_W-1] && (est_sum[EST_W-2:DATA_W-1] != '1)) begin
         est_sat = EST_MIN;
      end else begin
         est_sat = est_sum[DATA_W-1:0];
      end
      cov_full = prod_cov[DEN_W+15:16] + {{(DEN_W-1){1'b0}}, prod_cov[15]};
      cov_new  = cov_full[DATA_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_PRED;
         ST_PRED: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_MST;
         ST_MST:  state_in = ST_MUL;
         ST_MUL:  if (mul_est_done) state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // filter state updates
   always_comb begin
      x_in         = x_ff;
      cov_in       = cov_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      if (req_xfer) begin
         seeded_in = 1'b1;
         if (!seeded_ff || req_restart) begin
            x_in = req_sample;
         end
      end
      if ((state_ff == ST_FIN) && out_free) begin
         x_in         = est_sat;
         cov_in       = cov_new;
         rsp_valid_in = 1'b1;
      end
      if (csr_xfer && (csr_index == CSR_INITIAL_COVARIANCE)) begin
         cov_in = csr_data;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ff         <= PROCESS_NOISE_RST;
         r_ff         <= MEASUREMENT_NOISE_RST;
         x_ff         <= '0;
         cov_ff       <= INITIAL_COVARIANCE_RST;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         cov_ff       <= cov_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         // initial covariance loads straight into the running covariance
         if (csr_xfer) begin
            unique case (csr_index)
               CSR_PROCESS_NOISE:     q_ff <= csr_data;
               CSR_MEASUREMENT_NOISE: r_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // working registers of one sample
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         z_ff <= req_sample;
      end
      if (state_ff == ST_PRED) begin
         p_ff     <= p_sat;
         dzero_ff <= (den == '0);
      end
      if ((state_ff == ST_DIV) && div_done) begin
         gain_ff <= dzero_ff ? '0 : div_quo;
      end
      if ((state_ff == ST_FIN) && out_free) begin
         rsp_est_ff  <= est_sat;
         rsp_gain_ff <= gain_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_estimate    = rsp_est_ff;
   assign rsp_kalman_gain = rsp_gain_ff;

   // the gain never exceeds one
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_gain_ff <= ONE_Q16))
      else $error("gain above one");

   // the updated covariance never exceeds the predicted one
   a_cov_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (cov_full <= {1'b0, p_ff}))
      else $error("covariance grew in update");

   // a new result only appears after the final step
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result without final step");

   // the divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done out of step");

   // both multipliers finish together, while the sequencer waits for them
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      (mul_est_done || mul_cov_done) |-> (mul_est_done && mul_cov_done &&
                                          (state_ff == ST_MUL)))
      else $error("multipliers out of step");

endmodule
